// ===== sv/assert_macros.svh =====
// Assertion macros shared by the alarm controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/das_pkg.sv =====
// Types and constants of the dual alarm setter and matcher.
package das_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [4:0] hour_t;
  typedef logic [5:0] minute_t;

  localparam mode_t MODE_RUN    = 2'd0;
  localparam mode_t MODE_EDIT_A = 2'd1;
  localparam mode_t MODE_EDIT_B = 2'd2;

  localparam hour_t   HOUR_MAX   = 5'd23;
  localparam minute_t MINUTE_MAX = 6'd59;

  localparam hour_t   ALARM_A_HOUR_RST   = 5'd12;
  localparam minute_t ALARM_A_MINUTE_RST = 6'd0;
  localparam hour_t   ALARM_B_HOUR_RST   = 5'd12;
  localparam minute_t ALARM_B_MINUTE_RST = 6'd30;

  typedef struct packed {
    hour_t   now_hour;
    minute_t now_minute;
    minute_t now_second;
    logic    set_button;
    logic    next_button;
    logic    up_button;
    logic    down_button;
  } das_in_t;

  typedef struct packed {
    mode_t   mode_now;
    logic    editing_minute;
    hour_t   alarm_a_hour_out;
    minute_t alarm_a_minute_out;
    hour_t   alarm_b_hour_out;
    minute_t alarm_b_minute_out;
    logic    alarm_hit;
  } das_out_t;

endpackage

// ===== sv/das_channels_if.sv =====
// Valid/ready channel interfaces for poll items and results.
interface das_in_if;
  import das_pkg::*;

  logic    valid;
  logic    ready;
  das_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface das_out_if;
  import das_pkg::*;

  logic     valid;
  logic     ready;
  das_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/das_in_stage.sv =====
// Input register stage: captures one poll item per transfer.
module das_in_stage (
  input  logic      clk,
  input  logic      rst_n,
  das_in_if.sink    in_ch,
  das_in_if.source  s1_ch
);
  import das_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  das_in_t data_r;
  logic    take;

  // Take a new item whenever the register is empty or drains this cycle
  assign in_ch.ready = !valid_r || s1_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (s1_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload until the next transfer
  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_ch.data;
    end
  end

  assign s1_ch.valid = valid_r;
  assign s1_ch.data  = data_r;

endmodule

// ===== sv/das_core.sv =====
// Alarm state, button edge logic, match test and result register.
`include "assert_macros.svh"

module das_core (
  input  logic      clk,
  input  logic      rst_n,
  das_in_if.sink    s1_ch,
  das_out_if.source out_ch
);
  import das_pkg::*;

  // State registers
  mode_t    mode_r, mode_nxt;
  logic     edit_minute_r, edit_minute_nxt;
  hour_t    a_hour_r, a_hour_nxt;
  minute_t  a_minute_r, a_minute_nxt;
  hour_t    b_hour_r, b_hour_nxt;
  minute_t  b_minute_r, b_minute_nxt;
  logic     set_last_r, next_last_r, up_last_r, down_last_r;
  logic     up_last_nxt, down_last_nxt;

  // Result register
  logic     out_valid_r, out_valid_nxt;
  das_out_t out_data_r, out_data_nxt;

  logic     fire;
  logic     set_edge, next_edge, up_edge, down_edge;
  logic     editing;
  mode_t    mode_step;
  logic     edit_step;
  hour_t    sel_hour, hour_up, hour_dn;
  minute_t  sel_minute, minute_up, minute_dn;
  logic     hit;

  assign s1_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = s1_ch.valid && s1_ch.ready;

  // Detect new presses against stored levels
  assign set_edge  = s1_ch.data.set_button && !set_last_r;
  assign next_edge = s1_ch.data.next_button && !next_last_r;

  // Step the mode and field select
  always_comb begin
    mode_step = mode_r;
    edit_step = edit_minute_r;
    if (set_edge) begin
      mode_step = (mode_r >= MODE_EDIT_B) ? MODE_RUN : mode_r + 2'd1;
      edit_step = 1'b0;
    end
    if (next_edge && (mode_step != MODE_RUN)) begin
      edit_step = !edit_step;
    end
  end

  assign editing   = (mode_step == MODE_EDIT_A) || (mode_step == MODE_EDIT_B);
  assign up_edge   = editing && s1_ch.data.up_button && !up_last_r;
  assign down_edge = editing && s1_ch.data.down_button && !down_last_r;

  // Freeze the up and down trackers outside edit modes
  assign up_last_nxt   = editing ? s1_ch.data.up_button : up_last_r;
  assign down_last_nxt = editing ? s1_ch.data.down_button : down_last_r;

  // Adjust the selected field: increment, then decrement, with wrap
  assign sel_hour   = (mode_step == MODE_EDIT_A) ? a_hour_r : b_hour_r;
  assign sel_minute = (mode_step == MODE_EDIT_A) ? a_minute_r : b_minute_r;

  always_comb begin
    hour_up   = sel_hour;
    minute_up = sel_minute;
    if (up_edge && !edit_step) begin
      hour_up = (sel_hour >= HOUR_MAX) ? '0 : sel_hour + 5'd1;
    end
    if (up_edge && edit_step) begin
      minute_up = (sel_minute >= MINUTE_MAX) ? '0 : sel_minute + 6'd1;
    end
    hour_dn   = hour_up;
    minute_dn = minute_up;
    if (down_edge && !edit_step) begin
      hour_dn = (hour_up == '0) ? HOUR_MAX : hour_up - 5'd1;
    end
    if (down_edge && edit_step) begin
      minute_dn = (minute_up == '0) ? MINUTE_MAX : minute_up - 6'd1;
    end
  end

  // Write back into the alarm being edited
  always_comb begin
    a_hour_nxt   = a_hour_r;
    a_minute_nxt = a_minute_r;
    b_hour_nxt   = b_hour_r;
    b_minute_nxt = b_minute_r;
    if (mode_step == MODE_EDIT_A) begin
      a_hour_nxt   = hour_dn;
      a_minute_nxt = minute_dn;
    end
    if (mode_step == MODE_EDIT_B) begin
      b_hour_nxt   = hour_dn;
      b_minute_nxt = minute_dn;
    end
  end

  assign mode_nxt        = mode_step;
  assign edit_minute_nxt = edit_step;

  // Match time against both alarms at second zero in normal mode
  assign hit = (mode_step == MODE_RUN) && (s1_ch.data.now_second == '0) &&
               (((s1_ch.data.now_hour == a_hour_nxt) &&
                 (s1_ch.data.now_minute == a_minute_nxt)) ||
                ((s1_ch.data.now_hour == b_hour_nxt) &&
                 (s1_ch.data.now_minute == b_minute_nxt)));

  always_comb begin
    out_data_nxt.mode_now           = mode_nxt;
    out_data_nxt.editing_minute     = edit_minute_nxt;
    out_data_nxt.alarm_a_hour_out   = a_hour_nxt;
    out_data_nxt.alarm_a_minute_out = a_minute_nxt;
    out_data_nxt.alarm_b_hour_out   = b_hour_nxt;
    out_data_nxt.alarm_b_minute_out = b_minute_nxt;
    out_data_nxt.alarm_hit          = hit;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Advance state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RUN;
      edit_minute_r <= 1'b0;
      a_hour_r      <= ALARM_A_HOUR_RST;
      a_minute_r    <= ALARM_A_MINUTE_RST;
      b_hour_r      <= ALARM_B_HOUR_RST;
      b_minute_r    <= ALARM_B_MINUTE_RST;
      set_last_r    <= 1'b0;
      next_last_r   <= 1'b0;
      up_last_r     <= 1'b0;
      down_last_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        mode_r        <= mode_nxt;
        edit_minute_r <= edit_minute_nxt;
        a_hour_r      <= a_hour_nxt;
        a_minute_r    <= a_minute_nxt;
        b_hour_r      <= b_hour_nxt;
        b_minute_r    <= b_minute_nxt;
        set_last_r    <= s1_ch.data.set_button;
        next_last_r   <= s1_ch.data.next_button;
        up_last_r     <= up_last_nxt;
        down_last_r   <= down_last_nxt;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `ASSERT_ALWAYS(a_alarms_in_range, clk, rst_n,
    (a_hour_r <= HOUR_MAX) && (b_hour_r <= HOUR_MAX) &&
    (a_minute_r <= MINUTE_MAX) && (b_minute_r <= MINUTE_MAX),
    "alarm value out of range")
  `ASSERT_IMPLY(a_normal_hour_field, clk, rst_n, mode_r == MODE_RUN, !edit_minute_r,
    "minute field selected in normal mode")
  `ASSERT_IMPLY(a_hit_only_normal, clk, rst_n, out_valid_r && out_data_r.alarm_hit,
    out_data_r.mode_now == MODE_RUN, "alarm hit flagged while editing")
  `ASSERT_NEXT(a_hold_when_idle, clk, rst_n, !fire,
    $stable(mode_r) && $stable(a_hour_r) && $stable(b_minute_r) && $stable(set_last_r),
    "state changed without a transfer")
  `ASSERT_NEXT(a_normal_keeps_alarms, clk, rst_n,
    fire && (mode_r == MODE_RUN) && !set_edge,
    $stable(a_hour_r) && $stable(a_minute_r) && $stable(b_hour_r) && $stable(b_minute_r),
    "alarm changed in normal mode")

endmodule

// ===== sv/dual_alarm_setter_and_matcher.sv =====
// Top level of the dual alarm setter and matcher.
// Path: a poll item passes the input register, then the result register in das_core.
// Throughput: one poll item per cycle while out_ch.ready holds; the input register
// and the result register each accept a new item in the cycle they drain.
// Reset: synchronous active-low rst_n clears both valid flags, selects normal
// mode and hour field, loads alarms to 12:00 and 12:30, clears button levels.
module dual_alarm_setter_and_matcher (
  input  logic      clk,
  input  logic      rst_n,
  das_in_if.sink    in_ch,
  das_out_if.source out_ch
);
  import das_pkg::*;

  das_in_if s1_ch ();

  das_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .s1_ch (s1_ch)
  );

  das_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_ch  (s1_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== tb/dual_alarm_setter_and_matcher_tb.sv =====
// Self-checking testbench of the dual alarm setter and matcher.
module dual_alarm_setter_and_matcher_tb;
  import das_pkg::*;

  localparam int RANDOM_POLLS = 850;
  localparam int CALM_TAIL    = 120;
  localparam int CYCLE_LIMIT  = 200000;

  // Edit state and button history of the controller
  typedef struct packed {
    mode_t   mode;
    logic    minute_sel;
    hour_t   a_hour;
    minute_t a_minute;
    hour_t   b_hour;
    minute_t b_minute;
    logic    set_prev;
    logic    next_prev;
    logic    up_prev;
    logic    down_prev;
  } alarm_state_t;

  logic clk = 1'b0;
  logic rst_n;

  das_in_if  in_ch ();
  das_out_if out_ch ();

  dual_alarm_setter_and_matcher u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  das_in_t      poll_q[$];
  das_out_t     result_q[$];
  alarm_state_t gen_state;
  alarm_state_t pred_state;
  int           poll_total = 0;
  int           sent_cnt   = 0;
  int           failures   = 0;
  int           cycles     = 0;
  int           in_gap     = 0;
  int           out_stall  = 0;

  function automatic alarm_state_t alarm_reset_state();
    alarm_state_t s;
    s          = '0;
    s.mode     = MODE_RUN;
    s.a_hour   = ALARM_A_HOUR_RST;
    s.a_minute = ALARM_A_MINUTE_RST;
    s.b_hour   = ALARM_B_HOUR_RST;
    s.b_minute = ALARM_B_MINUTE_RST;
    return s;
  endfunction

  // Step the selected field of the alarm under edit, with wrap
  function automatic alarm_state_t alarm_nudge(alarm_state_t s, logic up);
    hour_t   h;
    minute_t m;
    h = (s.mode == MODE_EDIT_A) ? s.a_hour : s.b_hour;
    m = (s.mode == MODE_EDIT_A) ? s.a_minute : s.b_minute;
    if (!s.minute_sel) begin
      if (up) h = (h >= HOUR_MAX) ? hour_t'(0) : hour_t'(h + 1);
      else    h = (h == 0) ? HOUR_MAX : hour_t'(h - 1);
    end else begin
      if (up) m = (m >= MINUTE_MAX) ? minute_t'(0) : minute_t'(m + 1);
      else    m = (m == 0) ? MINUTE_MAX : minute_t'(m - 1);
    end
    if (s.mode == MODE_EDIT_A) begin
      s.a_hour   = h;
      s.a_minute = m;
    end else begin
      s.b_hour   = h;
      s.b_minute = m;
    end
    return s;
  endfunction

  // Apply one polling pass: SET, then NEXT, then UP, then DOWN
  function automatic alarm_state_t alarm_next(alarm_state_t s, das_in_t p);
    alarm_state_t n;
    logic         up_press;
    logic         down_press;
    n = s;
    if (p.set_button && !s.set_prev) begin
      case (s.mode)
        MODE_RUN:    n.mode = MODE_EDIT_A;
        MODE_EDIT_A: n.mode = MODE_EDIT_B;
        default:     n.mode = MODE_RUN;
      endcase
      n.minute_sel = 1'b0;
    end
    n.set_prev = p.set_button;
    if (p.next_button && !s.next_prev && n.mode != MODE_RUN)
      n.minute_sel = !n.minute_sel;
    n.next_prev = p.next_button;
    // up and down history is frozen outside edit modes
    if (n.mode == MODE_EDIT_A || n.mode == MODE_EDIT_B) begin
      up_press    = p.up_button && !s.up_prev;
      down_press  = p.down_button && !s.down_prev;
      n.up_prev   = p.up_button;
      n.down_prev = p.down_button;
      if (up_press)   n = alarm_nudge(n, 1'b1);
      if (down_press) n = alarm_nudge(n, 1'b0);
    end
    return n;
  endfunction

  // Result of a pass from the state after it
  function automatic das_out_t poll_result(alarm_state_t s, das_in_t p);
    das_out_t r;
    r.mode_now           = s.mode;
    r.editing_minute     = s.minute_sel;
    r.alarm_a_hour_out   = s.a_hour;
    r.alarm_a_minute_out = s.a_minute;
    r.alarm_b_hour_out   = s.b_hour;
    r.alarm_b_minute_out = s.b_minute;
    r.alarm_hit = (s.mode == MODE_RUN) && (p.now_second == 0) &&
                  ((p.now_hour == s.a_hour && p.now_minute == s.a_minute) ||
                   (p.now_hour == s.b_hour && p.now_minute == s.b_minute));
    return r;
  endfunction

  // Queue one pass and track the state it leads to for biasing later times
  task automatic queue_poll(input hour_t h, input minute_t m, input minute_t sec,
                            input logic [3:0] btn);
    das_in_t p;
    p.now_hour    = h;
    p.now_minute  = m;
    p.now_second  = sec;
    p.set_button  = btn[3];
    p.next_button = btn[2];
    p.up_button   = btn[1];
    p.down_button = btn[0];
    poll_q.push_back(p);
    gen_state = alarm_next(gen_state, p);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Idling is allowed except in every third block of 64 passes and in the tail
  function automatic logic choppy();
    return (poll_q.size() > CALM_TAIL) && ((sent_cnt / 64) % 3 != 0);
  endfunction

  // Driver: predict each transfer, then offer the next pending pass
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pred_state = alarm_next(pred_state, in_ch.data);
        result_q.push_back(poll_result(pred_state, in_ch.data));
        sent_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (poll_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= poll_q.pop_front();
          if (choppy() && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 15);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: stall in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (choppy() && $urandom_range(0, 7) == 0) out_stall = $urandom_range(1, 15);
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    das_out_t want;
    das_out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (result_q.size() == 0) begin
        $error("result transfer with no pass outstanding");
        failures++;
      end else begin
        want = result_q.pop_front();
        check_field("mode_now", 32'(want.mode_now), 32'(got.mode_now));
        check_field("editing_minute", 32'(want.editing_minute),
                    32'(got.editing_minute));
        check_field("alarm_a_hour_out", 32'(want.alarm_a_hour_out),
                    32'(got.alarm_a_hour_out));
        check_field("alarm_a_minute_out", 32'(want.alarm_a_minute_out),
                    32'(got.alarm_a_minute_out));
        check_field("alarm_b_hour_out", 32'(want.alarm_b_hour_out),
                    32'(got.alarm_b_hour_out));
        check_field("alarm_b_minute_out", 32'(want.alarm_b_minute_out),
                    32'(got.alarm_b_minute_out));
        check_field("alarm_hit", 32'(want.alarm_hit), 32'(got.alarm_hit));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** dual_alarm_setter_and_matcher: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [3:0] btn;
    hour_t      h;
    minute_t    m;
    minute_t    sec;
    int         pick;

    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    gen_state    = alarm_reset_state();
    pred_state   = alarm_reset_state();

    // Directed: alarm hits at reset values, extremes, edge and wrap cases
    queue_poll(5'd12, 6'd0, 6'd0, 4'b0000);
    queue_poll(5'd12, 6'd30, 6'd0, 4'b0000);
    queue_poll(5'd12, 6'd0, 6'd1, 4'b0000);
    queue_poll(5'd31, 6'd63, 6'd63, 4'b0000);
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0010);   // up held in normal mode is ignored
    queue_poll(5'd0, 6'd0, 6'd0, 4'b1010);   // enter edit A, up counts at once
    queue_poll(5'd0, 6'd0, 6'd0, 4'b1010);   // held buttons change nothing
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0000);
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0100);   // select minute
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0001);   // minute 0 wraps down to 59
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0010);   // and back up to 0
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0100);   // back to hour
    queue_poll(5'd12, 6'd0, 6'd0, 4'b1000);  // edit B, no hit while editing
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0001);
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0101);   // down held, next selects minute
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0000);
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0011);   // up and down in one pass
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0000);
    queue_poll(5'd0, 6'd0, 6'd0, 4'b1100);   // back to normal, next ignored
    queue_poll(5'd13, 6'd0, 6'd0, 4'b0000);
    queue_poll(5'd11, 6'd30, 6'd0, 4'b0000);
    queue_poll(5'd11, 6'd30, 6'd0, 4'b1111); // edit A with every button pressed
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0000);
    queue_poll(5'd0, 6'd0, 6'd0, 4'b1000);
    queue_poll(5'd0, 6'd0, 6'd0, 4'b0000);

    // Random: button levels wander, times often land on an alarm
    btn = 4'b0000;
    for (int i = 0; i < RANDOM_POLLS; i++) begin
      if ($urandom_range(0, 9) == 0) btn[3] = !btn[3];
      if ($urandom_range(0, 3) == 0) btn[2] = !btn[2];
      if ($urandom_range(0, 2) == 0) btn[1] = !btn[1];
      if ($urandom_range(0, 2) == 0) btn[0] = !btn[0];
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        h   = $urandom_range(0, 1) ? gen_state.a_hour : gen_state.b_hour;
        m   = (h == gen_state.a_hour) ? gen_state.a_minute : gen_state.b_minute;
        sec = $urandom_range(0, 2) != 0 ? minute_t'(0) : minute_t'($urandom_range(0, 59));
      end else if (pick <= 6) begin
        h   = hour_t'($urandom_range(0, 23));
        m   = minute_t'($urandom_range(0, 59));
        sec = minute_t'($urandom_range(0, 59));
      end else if (pick <= 8) begin
        h   = gen_state.a_hour;
        m   = minute_t'(gen_state.a_minute + $urandom_range(0, 2) - 1);
        sec = 6'd0;
      end else begin
        h   = hour_t'($urandom_range(0, 31));
        m   = minute_t'($urandom_range(0, 63));
        sec = minute_t'($urandom_range(0, 63));
        btn = 4'($urandom_range(0, 15));
      end
      queue_poll(h, m, sec, btn);
    end
    poll_total = poll_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all passes sent, all results back, then a short settle
    while (sent_cnt < poll_total || result_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (failures == 0)
      $display("** dual_alarm_setter_and_matcher: PASSED **");
    else
      $display("** dual_alarm_setter_and_matcher: FAILED **");
    $finish;
  end

endmodule
